// File: src/csvls_pkg.sv
// ----------------------------------------------------------------------------
// csvls_pkg
// Shared types, constants and helpers of the csv line field splitter.
// ----------------------------------------------------------------------------
package csvls_pkg;

   // depth of the trailing whitespace buffer
   localparam int WS_DEPTH = 16;
   localparam int WS_IDX_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int WS_CNT_W = $clog2(WS_DEPTH + 1);

   // depth of the command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DELIMITER = 1'b0;
   localparam logic REG_QUOTE     = 1'b1;
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;

   typedef logic [WS_IDX_W-1:0] idx_type;
   typedef logic [WS_CNT_W-1:0] cnt_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_FIELD = 2'd1,
      KIND_LAST  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   // byte operations handed from front to back
   typedef enum logic [1:0] {
      OP_NONE      = 2'd0,
      OP_APPEND    = 2'd1,
      OP_FIELD_END = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       ws_overflow;
      logic       last;
   } rsp_type;

   // one classified input beat
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       is_ws;
      logic       eol;
      logic       eol_error;
   } cmd_type;

   // space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_ws(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

endpackage

// File: src/csvls_front.sv
// ----------------------------------------------------------------------------
// csvls_front
// Accepts input beats, tracks quoting and field state, and turns each beat
// into at most one command for the back part.
// ----------------------------------------------------------------------------
module csvls_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvls_pkg::req_type  req_item,
   input  logic [7:0]          delimiter,
   input  logic [7:0]          quote,
   input  logic                q_full,
   output logic                q_push,
   output csvls_pkg::cmd_type  q_data
);

   logic in_quotes_ff, in_quotes_in;
   logic quote_pending_ff, quote_pending_in;
   logic field_started_ff, field_started_in;
   logic line_stopped_ff, line_stopped_in;
   logic accept;
   logic handled;
   csvls_pkg::cmd_type cmd;

   assign accept = push && !q_full;

   // classify one beat
   always_comb begin
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      field_started_in = field_started_ff;
      line_stopped_in  = line_stopped_ff;
      handled          = 1'b0;
      cmd              = '0;
      cmd.op           = csvls_pkg::OP_NONE;
      cmd.data         = req_item.in_byte;
      cmd.is_ws        = csvls_pkg::is_ws(req_item.in_byte);
      if (accept) begin
         // byte part
         if (req_item.has_byte && !line_stopped_ff) begin
            // a pending quote is resolved by this byte
            if (quote_pending_ff) begin
               quote_pending_in = 1'b0;
               if (req_item.in_byte != 8'd0 && req_item.in_byte == quote) begin
                  cmd.op           = csvls_pkg::OP_APPEND;
                  field_started_in = 1'b1;
                  handled          = 1'b1;
               end else begin
                  in_quotes_in = !in_quotes_in;
               end
            end
            if (!handled) begin
               if (req_item.in_byte == 8'd0) begin
                  line_stopped_in = 1'b1;
               end else if (req_item.in_byte == quote) begin
                  quote_pending_in = 1'b1;
               end else if (req_item.in_byte == delimiter && !in_quotes_in) begin
                  cmd.op           = csvls_pkg::OP_FIELD_END;
                  field_started_in = 1'b0;
               end else if (!cmd.is_ws || field_started_in) begin
                  cmd.op           = csvls_pkg::OP_APPEND;
                  field_started_in = 1'b1;
               end
            end
         end
         // line end part
         if (req_item.end_of_line) begin
            if (quote_pending_in) begin
               in_quotes_in = !in_quotes_in;
            end
            cmd.eol          = 1'b1;
            cmd.eol_error    = in_quotes_in;
            in_quotes_in     = 1'b0;
            quote_pending_in = 1'b0;
            field_started_in = 1'b0;
            line_stopped_in  = 1'b0;
         end
      end
   end

   // only beats with visible work go to the back
   assign q_push = accept && (cmd.op != csvls_pkg::OP_NONE || cmd.eol);
   assign q_data = cmd;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         field_started_ff <= 1'b0;
         line_stopped_ff  <= 1'b0;
      end else begin
         in_quotes_ff     <= in_quotes_in;
         quote_pending_ff <= quote_pending_in;
         field_started_ff <= field_started_in;
         line_stopped_ff  <= line_stopped_in;
      end
   end

   // a zero byte always resolves a pending quote first
   assert property (@(posedge clock) disable iff (reset)
      line_stopped_ff |-> !quote_pending_ff)
      else $error("quote pending while line is stopped");

   // a line end leaves a clean parser
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.end_of_line) |=>
         (!in_quotes_ff && !quote_pending_ff && !field_started_ff && !line_stopped_ff))
      else $error("parser state not cleared after line end");

endmodule

// File: src/csvls_cmd_queue.sv
// ----------------------------------------------------------------------------
// csvls_cmd_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csvls_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvls_pkg::cmd_type  data_in,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output csvls_pkg::cmd_type  data_out
);

   csvls_pkg::cmd_type entry_ff [csvls_pkg::CMD_DEPTH];
   logic [csvls_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [csvls_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [csvls_pkg::CMD_CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full     = (count_ff == csvls_pkg::CMD_CNT_W'(csvls_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == csvls_pkg::CMD_PTR_W'(csvls_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == csvls_pkg::CMD_PTR_W'(csvls_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_in;
      end
   end

   // the front never offers a command into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

endmodule

// File: src/csvls_back.sv
// ----------------------------------------------------------------------------
// csvls_back
// Carries out commands: holds trailing whitespace, flushes it one byte per
// cycle unless results stall, and emits data, field end and line end results.
// ----------------------------------------------------------------------------
module csvls_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  csvls_pkg::cmd_type  q_data,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output csvls_pkg::rsp_type  rsp_item
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FLUSH = 4'b0010,
      ST_BYTE  = 4'b0100,
      ST_EOL   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   csvls_pkg::cmd_type cmd_ff, cmd_in;
   csvls_pkg::cnt_type held_count_ff, held_count_in;
   csvls_pkg::idx_type rd_idx_ff, rd_idx_in;
   logic [7:0] held_ff [csvls_pkg::WS_DEPTH];
   logic [7:0] held_rd;
   logic wr_en;
   logic out_valid_ff, out_valid_in;
   csvls_pkg::rsp_type out_item_ff, out_item_in;
   csvls_pkg::rsp_type emit_item;
   logic emit;
   logic can_emit;
   logic done;
   logic flush_end;

   // first phase of a fresh command
   function automatic state_type start_phase(input csvls_pkg::cmd_type c,
                                             input csvls_pkg::cnt_type cnt);
      state_type s;
      if (c.op == csvls_pkg::OP_APPEND &&
          ((!c.is_ws && cnt != '0) ||
           (c.is_ws && cnt == csvls_pkg::cnt_type'(csvls_pkg::WS_DEPTH)))) begin
         s = ST_FLUSH;
      end else if (c.op != csvls_pkg::OP_NONE) begin
         s = ST_BYTE;
      end else begin
         s = ST_EOL;
      end
      return s;
   endfunction

   assign held_rd   = held_ff[rd_idx_ff];
   assign can_emit  = !out_valid_ff || pop;
   assign flush_end = (csvls_pkg::cnt_type'(rd_idx_ff) + 1'b1 == held_count_ff);

   // phase sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      held_count_in = held_count_ff;
      rd_idx_in     = rd_idx_ff;
      out_valid_in  = out_valid_ff && !pop;
      out_item_in   = out_item_ff;
      emit          = 1'b0;
      emit_item     = '0;
      emit_item.kind = csvls_pkg::KIND_DATA;
      done          = 1'b0;
      wr_en         = 1'b0;
      q_pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            done = 1'b1;
         end
         ST_FLUSH: begin
            // one held byte per beat while the result register can take it
            emit                  = 1'b1;
            emit_item.out_byte    = held_rd;
            emit_item.ws_overflow = cmd_ff.is_ws;
            emit_item.last        = flush_end && cmd_ff.is_ws && !cmd_ff.eol;
            if (can_emit) begin
               if (flush_end) begin
                  rd_idx_in     = '0;
                  held_count_in = '0;
                  state_in      = ST_BYTE;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end
         ST_BYTE: begin
            case (cmd_ff.op)
               csvls_pkg::OP_APPEND: begin
                  if (cmd_ff.is_ws) begin
                     // hold trailing whitespace, no result yet
                     wr_en         = 1'b1;
                     held_count_in = held_count_ff + 1'b1;
                     if (cmd_ff.eol) begin
                        state_in = ST_EOL;
                     end else begin
                        done = 1'b1;
                     end
                  end else begin
                     emit               = 1'b1;
                     emit_item.out_byte = cmd_ff.data;
                     emit_item.last     = !cmd_ff.eol;
                     if (can_emit) begin
                        if (cmd_ff.eol) begin
                           state_in = ST_EOL;
                        end else begin
                           done = 1'b1;
                        end
                     end
                  end
               end
               csvls_pkg::OP_FIELD_END: begin
                  // held whitespace of the field is dropped
                  emit           = 1'b1;
                  emit_item.kind = csvls_pkg::KIND_FIELD;
                  emit_item.last = !cmd_ff.eol;
                  if (can_emit) begin
                     held_count_in = '0;
                     if (cmd_ff.eol) begin
                        state_in = ST_EOL;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               default: begin
                  if (cmd_ff.eol) begin
                     state_in = ST_EOL;
                  end else begin
                     done = 1'b1;
                  end
               end
            endcase
         end
         ST_EOL: begin
            emit           = 1'b1;
            emit_item.kind = cmd_ff.eol_error ? csvls_pkg::KIND_ERROR : csvls_pkg::KIND_LAST;
            emit_item.last = 1'b1;
            if (can_emit) begin
               held_count_in = '0;
               done          = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result register
      if (emit && can_emit) begin
         out_valid_in = 1'b1;
         out_item_in  = emit_item;
      end

      // take the next command as soon as this one is finished
      if (done) begin
         if (q_empty) begin
            state_in = ST_IDLE;
         end else begin
            q_pop    = 1'b1;
            cmd_in   = q_data;
            state_in = start_phase(q_data, held_count_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         rd_idx_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         rd_idx_ff     <= rd_idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_item_ff <= out_item_in;
   end

   // whitespace buffer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         held_ff[held_count_ff[csvls_pkg::WS_IDX_W-1:0]] <= cmd_ff.data;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = out_item_ff;

   // buffer fill never passes its depth
   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= csvls_pkg::cnt_type'(csvls_pkg::WS_DEPTH))
      else $error("whitespace count beyond buffer depth");

   // a flush only walks over held entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |->
         (held_count_ff != '0 && csvls_pkg::cnt_type'(rd_idx_ff) < held_count_ff))
      else $error("flush index outside held whitespace");

endmodule

// File: src/csv_line_field_splitter_core.sv
// ----------------------------------------------------------------------------
// csv_line_field_splitter_core
// Splits text lines, fed a byte per beat, into field bytes and field ends.
// ----------------------------------------------------------------------------
// A front part takes one input beat per cycle while the queue is not full
// and classifies it against the quoting state; a four-entry command queue
// carries the work to a back part that produces at most one result per cycle
// into a result register. Held trailing whitespace is flushed one byte per
// cycle while the result register can take it: a content byte after held
// whitespace first flushes it and then emits itself, a whitespace byte that
// finds the buffer full flushes every held byte and is then held itself, and
// a byte with a line end adds the line end result. The front keeps accepting
// while the back works until the queue fills. A result passes through the
// queue, the command register and the result register. The user must write
// delimiter (address 0) and quote (address 4) only while the block is idle;
// the block itself does not enforce it.
module csv_line_field_splitter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  csvls_pkg::req_type                   req_item,
   output logic                                 empty,
   input  logic                                 pop,
   output csvls_pkg::rsp_type                   rsp_item,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [csvls_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [csvls_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [csvls_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);

   logic [7:0] delimiter_ff, delimiter_in;
   logic [7:0] quote_ff, quote_in;
   logic csr_write;
   logic q_full;
   logic q_push;
   logic q_empty;
   logic q_pop;
   csvls_pkg::cmd_type q_wr_data;
   csvls_pkg::cmd_type q_rd_data;

   // register access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      delimiter_in = delimiter_ff;
      quote_in     = quote_ff;
      if (csr_write) begin
         case (paddr[2])
            csvls_pkg::REG_DELIMITER: delimiter_in = pwdata[7:0];
            csvls_pkg::REG_QUOTE:     quote_in     = pwdata[7:0];
            default:                  delimiter_in = delimiter_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         csvls_pkg::REG_DELIMITER: prdata = {24'd0, delimiter_ff};
         csvls_pkg::REG_QUOTE:     prdata = {24'd0, quote_ff};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= csvls_pkg::DELIMITER_RESET;
         quote_ff     <= csvls_pkg::QUOTE_RESET;
      end else begin
         delimiter_ff <= delimiter_in;
         quote_ff     <= quote_in;
      end
   end

   assign full = q_full;

   // classification
   csvls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .delimiter (delimiter_ff),
      .quote     (quote_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   // command queue
   csvls_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wr_data),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_rd_data)
   );

   // result generation
   csvls_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
